// File: sv/delimited_frame_field_splitter_defines.svh
// Assertion macros for the frame splitter RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef DELIMITED_FRAME_FIELD_SPLITTER_DEFINES_SVH
`define DELIMITED_FRAME_FIELD_SPLITTER_DEFINES_SVH

// Same-cycle implication, gated off during reset.
`define DFFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated off during reset.
`define DFFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/dffs_pkg.sv
// Shared types and constants for the delimited frame field splitter.
// No dependencies; imported by the drain sequencer and the top level.
`timescale 1ns / 1ps
`default_nettype none

package dffs_pkg;

    localparam int BYTE_W    = 8;
    localparam int FIELD_W   = 6;
    localparam int STORE_MAX = 62;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BEGIN_CHAR     = 2'd0,
        CFG_SEPARATOR_CHAR = 2'd1,
        CFG_END_CHAR       = 2'd2
    } cfg_reg_t;

endpackage

`default_nettype wire

// File: sv/dffs_body_ram.sv
// Body byte store: single write port, one registered read port.
// No dependencies; instantiated by the top level.
`timescale 1ns / 1ps
`default_nettype none

module dffs_body_ram #(
    parameter int DEPTH  = 62,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: sv/dffs_drain.sv
// Drain sequencer: reads a stored body back and emits it beat by beat.
// Depends on dffs_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "delimited_frame_field_splitter_defines.svh"

module dffs_drain
    import dffs_pkg::*;
#(
    parameter int LEN_W  = 6,
    parameter int ADDR_W = 6
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [LEN_W-1:0]   count,
    input  wire logic [BYTE_W-1:0]  sep_char,
    output logic                    rd_en,
    output logic      [ADDR_W-1:0]  rd_addr,
    input  wire logic [BYTE_W-1:0]  rd_data,
    output logic                    busy,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [BYTE_W-1:0]  m_body_byte,
    output logic      [FIELD_W-1:0] m_field_number,
    output logic                    m_is_separator,
    output logic                    m_last_of_message
);

    logic [LEN_W-1:0]   count_reg, count_next;
    logic [LEN_W-1:0]   issue_idx_reg, issue_idx_next;
    logic [LEN_W-1:0]   load_idx_reg, load_idx_next;
    logic               pending_reg, pending_next;
    logic               out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0] field_cnt_reg, field_cnt_next;
    logic [BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic [FIELD_W-1:0] out_field_reg, out_field_next;
    logic               out_sep_reg, out_sep_next;
    logic               out_last_reg, out_last_next;

    logic issue_left;
    logic load_now;
    logic issue_now;
    logic byte_is_sep;
    logic load_last;

    assign issue_left  = issue_idx_reg < count_reg;
    assign load_now    = pending_reg && (!out_valid_reg || m_ready);
    assign issue_now   = issue_left && (!pending_reg || load_now);
    assign byte_is_sep = rd_data == sep_char;
    assign load_last   = LEN_W'(load_idx_reg + 1'b1) == count_reg;

    assign rd_en   = issue_now;
    assign rd_addr = issue_idx_reg[ADDR_W-1:0];
    assign busy    = issue_left || pending_reg || out_valid_reg;

    always_comb begin
        count_next     = count_reg;
        issue_idx_next = issue_idx_reg;
        load_idx_next  = load_idx_reg;
        field_cnt_next = field_cnt_reg;
        out_byte_next  = out_byte_reg;
        out_field_next = out_field_reg;
        out_sep_next   = out_sep_reg;
        out_last_next  = out_last_reg;

        // Drop the output beat once taken; a fresh load overrides below.
        out_valid_next = out_valid_reg && !m_ready;
        pending_next   = pending_reg && !load_now;

        if (issue_now) begin
            issue_idx_next = LEN_W'(issue_idx_reg + 1'b1);
            pending_next   = 1'b1;
        end

        if (load_now) begin
            out_valid_next = 1'b1;
            out_byte_next  = rd_data;
            out_field_next = field_cnt_reg;
            out_sep_next   = byte_is_sep;
            out_last_next  = load_last;
            load_idx_next  = LEN_W'(load_idx_reg + 1'b1);
            if (byte_is_sep) begin
                field_cnt_next = FIELD_W'(field_cnt_reg + 1'b1);
            end
        end

        if (start) begin
            count_next     = count;
            issue_idx_next = '0;
            load_idx_next  = '0;
            field_cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            issue_idx_reg <= '0;
            load_idx_reg  <= '0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            field_cnt_reg <= '0;
        end else begin
            count_reg     <= count_next;
            issue_idx_reg <= issue_idx_next;
            load_idx_reg  <= load_idx_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
            field_cnt_reg <= field_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg  <= out_byte_next;
        out_field_reg <= out_field_next;
        out_sep_reg   <= out_sep_next;
        out_last_reg  <= out_last_next;
    end

    assign m_valid           = out_valid_reg;
    assign m_body_byte       = out_byte_reg;
    assign m_field_number    = out_field_reg;
    assign m_is_separator    = out_sep_reg;
    assign m_last_of_message = out_last_reg;

    `DFFS_ASSERT_NOW(a_start_when_idle, aclk, aresetn, start, !busy, "drain started while busy")
    `DFFS_ASSERT_NOW(a_one_read_in_flight, aclk, aresetn, pending_reg, issue_idx_reg == LEN_W'(load_idx_reg + 1'b1), "read tracking out of step")
    `DFFS_ASSERT_NEXT(a_idle_after_last, aclk, aresetn, m_valid && m_ready && m_last_of_message, !busy, "drain still busy after last beat")

endmodule

`default_nettype wire

// File: sv/delimited_frame_field_splitter.sv
// Delimited frame field splitter. Takes one received byte per input beat and
// drops line feed, carriage return and NUL. A begin character opens (or
// restarts) a frame; bytes outside a frame are discarded; an end character
// closes the frame and, if the body is non-empty and fit in the
// WINDOW_SIZE-2 byte store (at most 62), replays it as one output beat per
// byte tagged with field number, separator mark and last flag. A closing byte
// starts a drain of n stored bytes out of the body RAM (one write port, one
// registered read port): the first beat passes through the drain's length
// register, the RAM read register and the output register, then one beat
// per cycle while m_ready is high, and the input side is held off until the
// drain is done. Configuration writes are accepted every cycle; write them
// only while the block is idle. Depends on dffs_pkg, dffs_body_ram and
// dffs_drain.
`timescale 1ns / 1ps
`default_nettype none

module delimited_frame_field_splitter
    import dffs_pkg::*;
#(
    parameter int WINDOW_SIZE = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_data,
    // Received bytes
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [BYTE_W-1:0]    s_rx_byte,
    // Message body beats
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic      [BYTE_W-1:0]    m_body_byte,
    output logic      [FIELD_W-1:0]   m_field_number,
    output logic                      m_is_separator,
    output logic                      m_last_of_message
);

    // Body capacity, clamped to the largest store the field number can tag.
    localparam int BODY_CAP = (WINDOW_SIZE - 2) > STORE_MAX ? STORE_MAX : (WINDOW_SIZE - 2);
    localparam int LEN_W    = $clog2(BODY_CAP + 1);
    localparam int ADDR_W   = $clog2(BODY_CAP);

    // Configuration registers
    logic [BYTE_W-1:0] begin_char_reg, begin_char_next;
    logic [BYTE_W-1:0] sep_char_reg, sep_char_next;
    logic [BYTE_W-1:0] end_char_reg, end_char_next;

    // Frame state
    logic             in_frame_reg, in_frame_next;
    logic             overflow_reg, overflow_next;
    logic [LEN_W-1:0] body_len_reg, body_len_next;

    logic              accept;
    logic              dropped;
    logic              is_end;
    logic              is_begin;
    logic              is_body;
    logic              room;
    logic              wr_en;
    logic              drain_start;
    logic              drain_busy;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;

    // Config port never stalls.
    assign cfg_ready = 1'b1;

    always_comb begin
        begin_char_next = begin_char_reg;
        sep_char_next   = sep_char_reg;
        end_char_next   = end_char_reg;
        if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                CFG_BEGIN_CHAR:     begin_char_next = cfg_data;
                CFG_SEPARATOR_CHAR: sep_char_next   = cfg_data;
                CFG_END_CHAR:       end_char_next   = cfg_data;
                default: begin
                    // Unmapped index: ignore the write.
                end
            endcase
        end
    end

    // Hold off new bytes while a body is being replayed out of the RAM.
    assign s_ready = !drain_busy;
    assign accept  = s_valid && s_ready;

    // Classify the byte: filler first, then end, then begin, then body.
    assign dropped  = (s_rx_byte == CHAR_LF) || (s_rx_byte == CHAR_CR) ||
                      (s_rx_byte == CHAR_NUL);
    assign is_end   = !dropped && (s_rx_byte == end_char_reg);
    assign is_begin = !dropped && !is_end && (s_rx_byte == begin_char_reg);
    assign is_body  = !dropped && !is_end && !is_begin && in_frame_reg;
    assign room     = body_len_reg < LEN_W'(BODY_CAP);

    assign wr_en       = accept && is_body && room;
    assign drain_start = accept && is_end && in_frame_reg &&
                         (body_len_reg != '0) && !overflow_reg;

    always_comb begin
        in_frame_next = in_frame_reg;
        overflow_next = overflow_reg;
        body_len_next = body_len_reg;
        if (accept) begin
            if (is_end) begin
                // Close the frame; the drain takes the length captured now.
                in_frame_next = 1'b0;
                overflow_next = 1'b0;
                body_len_next = '0;
            end else if (is_begin) begin
                // Open or restart with an empty body.
                in_frame_next = 1'b1;
                overflow_next = 1'b0;
                body_len_next = '0;
            end else if (is_body) begin
                if (room) begin
                    body_len_next = LEN_W'(body_len_reg + 1'b1);
                end else begin
                    overflow_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            begin_char_reg <= '0;
            sep_char_reg   <= '0;
            end_char_reg   <= '0;
            in_frame_reg   <= 1'b0;
            overflow_reg   <= 1'b0;
            body_len_reg   <= '0;
        end else begin
            begin_char_reg <= begin_char_next;
            sep_char_reg   <= sep_char_next;
            end_char_reg   <= end_char_next;
            in_frame_reg   <= in_frame_next;
            overflow_reg   <= overflow_next;
            body_len_reg   <= body_len_next;
        end
    end

    // Body store: written at the fill point, read back only by the drain.
    // Intake stalls during a drain, so reads and writes never meet.
    dffs_body_ram #(
        .DEPTH  (BODY_CAP),
        .ADDR_W (ADDR_W),
        .DATA_W (BYTE_W)
    ) u_body_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (body_len_reg[ADDR_W-1:0]),
        .wr_data (s_rx_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dffs_drain #(
        .LEN_W  (LEN_W),
        .ADDR_W (ADDR_W)
    ) u_drain (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .start             (drain_start),
        .count             (body_len_reg),
        .sep_char          (sep_char_reg),
        .rd_en             (rd_en),
        .rd_addr           (rd_addr),
        .rd_data           (rd_data),
        .busy              (drain_busy),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_body_byte       (m_body_byte),
        .m_field_number    (m_field_number),
        .m_is_separator    (m_is_separator),
        .m_last_of_message (m_last_of_message)
    );

endmodule

`default_nettype wire
